// ===== sv/rational_arith_unit_macros.svh =====
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RAU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rau_pkg.sv =====
// types, constants and helpers of the rational arithmetic unit
`default_nettype none
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int W             = 64;
    localparam int LIM_W         = 31;
    localparam int CNT_W         = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    localparam logic CFG_IDX_ADD_LIMIT = 1'b0;
    localparam logic CFG_IDX_MUL_LIMIT = 1'b1;
    localparam logic [LIM_W-1:0] LIMIT_RESET = {LIM_W{1'b1}};

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_INT  = 3'd4,
        ACT_FRAC = 3'd5
    } t_action;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    typedef struct packed {
        logic         done;
        logic [W-1:0] q;
        logic [W-1:0] r;
    } t_mdu_rsp;

    typedef struct packed {
        logic [2:0]                action;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [W-1:0] res_num;
        logic signed [W-1:0] res_den;
    } t_out_item;

    function automatic logic [W-1:0] f_sext(logic [FIELD_W-1:0] v);
        return {{(W - OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
    endfunction

endpackage
`default_nettype wire

// ===== sv/rau_mdu.sv =====
// shared iterative multiply and truncating divide unit, one bit per cycle
`default_nettype none
module rau_mdu import rau_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mdu_req i_req,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    output t_mdu_rsp      o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_mdu_op          r_op;
    logic [W-1:0]     r_acc, r_x, r_y, r_rem;
    logic             r_negq, r_negr;

    logic [W-1:0] n_acc, n_x, n_y, n_rem;
    logic [W:0]   rem_sh;
    logic         geq;

    always_comb begin
        rem_sh = {r_rem, r_x[W-1]};
        geq    = rem_sh >= {1'b0, r_y};
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_rem  = r_rem;
        unique case (r_op)
            MDU_MUL: begin
                n_acc = r_y[0] ? r_acc + r_x : r_acc;
                n_x   = {r_x[W-2:0], 1'b0};
                n_y   = {1'b0, r_y[W-1:1]};
            end
            MDU_DIV: begin
                n_rem = geq ? W'(rem_sh - {1'b0, r_y}) : rem_sh[W-1:0];
                n_x   = {r_x[W-2:0], geq};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= MDU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_req.op;
                r_acc  <= '0;
                r_rem  <= '0;
                r_negq <= i_x[W-1] ^ i_y[W-1];
                r_negr <= i_x[W-1];
                if (i_req.op == MDU_MUL) begin
                    r_x <= i_x;
                    r_y <= i_y;
                end else begin
                    r_x <= i_x[W-1] ? -i_x : i_x;
                    r_y <= i_y[W-1] ? -i_y : i_y;
                end
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_x   <= n_x;
                r_y   <= n_y;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.q    = (r_op == MDU_MUL) ? r_acc : (r_negq ? -r_x : r_x);
        o_rsp.r    = r_negr ? -r_rem : r_rem;
    end

endmodule
`default_nettype wire

// ===== sv/rational_arith_unit.sv =====
// rational arithmetic unit: add, subtract, multiply, divide, integer and fractional part
//
// input channel: i_in_valid / o_in_stall with payload i_in (action and two fractions).
// a transaction is taken when valid is high and stall is low; stall stays high
// from the transaction until the result has been placed in the output register.
// output channel: o_out_valid / i_out_stall with payload o_out (res_num, res_den).
// the output register holds a result while the receiver stalls, and a new
// transaction can be taken meanwhile; the next result waits until it drains.
// configuration: i_cfg_we, i_cfg_idx, i_cfg_data write add_limit or mul_limit.
// integer and fractional part each take one divide on the shared unit; rejected,
// invalid and zero-addend cases go from the check straight to the output.
// add and multiply run three gcd reductions (one remainder per euclid step plus
// two divides each); add then needs three multiplies and multiply two.
// one transaction is in work at a time.
// reset: both limits return to 2147483647, the unit is idle and the output empty.
`default_nettype none
`include "rational_arith_unit_macros.svh"
module rational_arith_unit import rau_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [LIM_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_G_INIT, S_G_LOOP, S_G_WAIT, S_DN, S_DN_W, S_DD, S_DD_W,
        S_M1, S_M1_W, S_M2, S_M2_W, S_M3, S_M3_W, S_FIN, S_INT, S_INT_W,
        S_FRAC, S_FRAC_W, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_A, PH_B, PH_R} t_phase;

    t_state           r_state;
    t_phase           r_phase;
    t_action          r_act;
    logic [LIM_W-1:0] r_add_limit, r_mul_limit;
    logic [W-1:0]     r_an, r_ad, r_bn, r_bd, r_gn, r_gd, r_rn, r_rd;
    logic             r_out_valid;
    t_out_item        r_out;

    t_mdu_req         mdu_req;
    t_mdu_rsp         mdu_rsp;
    logic [W-1:0]     mdu_x, mdu_y;
    logic [W-1:0]     cur_n, cur_d;
    logic             is_add, is_mul, rejected;
    logic [LIM_W-1:0] lim;

    function automatic logic f_over(logic [W-1:0] v, logic [LIM_W-1:0] l);
        return $signed(v) > $signed({{(W - LIM_W){1'b0}}, l});
    endfunction

    always_comb begin
        is_add = (r_act == ACT_ADD) || (r_act == ACT_SUB);
        is_mul = (r_act == ACT_MUL) || (r_act == ACT_DIV);
        lim    = is_add ? r_add_limit : r_mul_limit;
        rejected = (r_ad == '0) || (r_bd == '0) || f_over(r_an, lim) ||
                   f_over(r_ad, lim) || f_over(r_bn, lim) || f_over(r_bd, lim);
        unique case (r_phase)
            PH_A:    begin cur_n = r_an; cur_d = r_ad; end
            PH_B:    begin cur_n = r_bn; cur_d = r_bd; end
            default: begin cur_n = r_rn; cur_d = r_rd; end
        endcase
    end

    always_comb begin
        mdu_req.start = 1'b0;
        mdu_req.op    = MDU_DIV;
        mdu_x         = r_an;
        mdu_y         = r_ad;
        unique case (r_state)
            S_G_LOOP: begin
                mdu_req.start = (r_gd != '0);
                mdu_x = r_gn;
                mdu_y = r_gd;
            end
            S_DN: begin
                mdu_req.start = 1'b1;
                mdu_x = cur_n;
                mdu_y = r_gn;
            end
            S_DD: begin
                mdu_req.start = 1'b1;
                mdu_x = cur_d;
                mdu_y = r_gn;
            end
            S_M1: begin
                mdu_req = '{start: 1'b1, op: MDU_MUL};
                mdu_x = r_an;
                mdu_y = is_add ? r_bd : r_bn;
            end
            S_M2: begin
                mdu_req = '{start: 1'b1, op: MDU_MUL};
                mdu_x = r_ad;
                mdu_y = r_bd;
            end
            S_M3: begin
                mdu_req = '{start: 1'b1, op: MDU_MUL};
                mdu_x = r_bn;
                mdu_y = r_ad;
            end
            S_INT, S_FRAC: mdu_req.start = 1'b1;
            default: ;
        endcase
    end

    rau_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .i_x     (mdu_x),
        .i_y     (mdu_y),
        .o_rsp   (mdu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_A;
            r_act       <= ACT_ADD;
            r_out_valid <= 1'b0;
            r_add_limit <= LIMIT_RESET;
            r_mul_limit <= LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDX_ADD_LIMIT: r_add_limit <= i_cfg_data;
                    CFG_IDX_MUL_LIMIT: r_mul_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= t_action'(i_in.action);
                        r_phase <= PH_A;
                        r_an    <= f_sext(i_in.a_num);
                        r_ad    <= f_sext(i_in.a_den);
                        r_bn    <= (t_action'(i_in.action) == ACT_SUB) ?
                                   -f_sext(i_in.b_num) :
                                   (t_action'(i_in.action) == ACT_DIV) ?
                                   f_sext(i_in.b_den) : f_sext(i_in.b_num);
                        r_bd    <= (t_action'(i_in.action) == ACT_DIV) ?
                                   f_sext(i_in.b_num) : f_sext(i_in.b_den);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (is_add && !rejected && r_an == '0) begin
                        r_rn    <= r_bd[W-1] ? -r_bn : r_bn;
                        r_rd    <= r_bd[W-1] ? -r_bd : r_bd;
                        r_state <= S_OUT;
                    end else if (is_add && !rejected && r_bn == '0) begin
                        r_rn    <= r_ad[W-1] ? -r_an : r_an;
                        r_rd    <= r_ad[W-1] ? -r_ad : r_ad;
                        r_state <= S_OUT;
                    end else if ((is_add || is_mul) && !rejected) begin
                        r_state <= S_G_INIT;
                    end else if (r_act == ACT_INT && r_ad != '0) begin
                        r_state <= S_INT;
                    end else if (r_act == ACT_FRAC && r_ad != '0) begin
                        r_an    <= r_ad[W-1] ? -r_an : r_an;
                        r_ad    <= r_ad[W-1] ? -r_ad : r_ad;
                        r_state <= S_FRAC;
                    end else begin
                        r_rn    <= '0;
                        r_rd    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_G_INIT: begin
                    r_gn    <= cur_n;
                    r_gd    <= cur_d;
                    r_state <= S_G_LOOP;
                end
                S_G_LOOP: r_state <= (r_gd == '0) ? S_DN : S_G_WAIT;
                S_G_WAIT: begin
                    if (mdu_rsp.done) begin
                        r_gn    <= r_gd;
                        r_gd    <= mdu_rsp.r;
                        r_state <= S_G_LOOP;
                    end
                end
                S_DN: r_state <= S_DN_W;
                S_DN_W: begin
                    if (mdu_rsp.done) begin
                        unique case (r_phase)
                            PH_A:    r_an <= mdu_rsp.q;
                            PH_B:    r_bn <= mdu_rsp.q;
                            default: r_rn <= mdu_rsp.q;
                        endcase
                        r_state <= S_DD;
                    end
                end
                S_DD: r_state <= S_DD_W;
                S_DD_W: begin
                    if (mdu_rsp.done) begin
                        unique case (r_phase)
                            PH_A: begin
                                r_ad    <= mdu_rsp.q;
                                r_phase <= PH_B;
                                r_state <= S_G_INIT;
                            end
                            PH_B: begin
                                r_bd    <= mdu_rsp.q;
                                r_state <= S_M1;
                            end
                            default: begin
                                r_rd    <= mdu_rsp.q;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_M1: r_state <= S_M1_W;
                S_M1_W: begin
                    if (mdu_rsp.done) begin
                        r_rn    <= mdu_rsp.q;
                        r_state <= S_M2;
                    end
                end
                S_M2: r_state <= S_M2_W;
                S_M2_W: begin
                    if (mdu_rsp.done) begin
                        r_rd <= mdu_rsp.q;
                        if (is_add) begin
                            r_state <= S_M3;
                        end else begin
                            r_phase <= PH_R;
                            r_state <= S_G_INIT;
                        end
                    end
                end
                S_M3: r_state <= S_M3_W;
                S_M3_W: begin
                    if (mdu_rsp.done) begin
                        r_rn    <= r_rn + mdu_rsp.q;
                        r_phase <= PH_R;
                        r_state <= S_G_INIT;
                    end
                end
                S_FIN: begin
                    if (is_mul && r_rn == '0) begin
                        r_rd <= '0;
                    end else if (r_rd[W-1]) begin
                        r_rn <= -r_rn;
                        r_rd <= -r_rd;
                    end
                    r_state <= S_OUT;
                end
                S_INT: r_state <= S_INT_W;
                S_INT_W: begin
                    if (mdu_rsp.done) begin
                        r_rn    <= mdu_rsp.q;
                        r_rd    <= W'(1);
                        r_state <= S_OUT;
                    end
                end
                S_FRAC: r_state <= S_FRAC_W;
                S_FRAC_W: begin
                    if (mdu_rsp.done) begin
                        r_rn    <= mdu_rsp.r;
                        r_rd    <= r_ad;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.res_num <= r_rn;
                        r_out.res_den <= r_rd;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `RAU_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall,
        "no stall after accepted transaction")
    `RAU_ASSERT_SAME(a_done_in_wait, mdu_rsp.done, r_state == S_G_WAIT ||
        r_state == S_DN_W || r_state == S_DD_W || r_state == S_M1_W ||
        r_state == S_M2_W || r_state == S_M3_W || r_state == S_INT_W ||
        r_state == S_FRAC_W, "shared unit finished outside a wait state")
    `RAU_ASSERT_SAME(a_invalid_is_zero, r_out_valid && r_out.res_den == '0,
        r_out.res_num == '0, "zero denominator with nonzero numerator")

endmodule
`default_nettype wire
